// ----- rtl/core/tvsn_pkg.sv -----
// Shared types, codes and constant tables of the two-voice square/noise sound generator.
// No dependencies; every other file in rtl/core except tvsn_checker imports this package.

package tvsn_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_WHOLE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_FRACTION = 2'd2;

    localparam logic [17:0] SAMPLE_RATE_RESET   = 18'd44100;
    localparam logic [15:0] STEP_WHOLE_RESET    = 16'd20;
    localparam logic [17:0] STEP_FRACTION_RESET = 18'd4724;

    // Input commands
    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_WRITE  = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    // Register window
    localparam logic [7:0] ADDR_FIRST   = 8'h0e;
    localparam logic [7:0] ADDR_LAST    = 8'h12;
    localparam logic [7:0] READ_HI_MASK = 8'hc0;

    localparam logic [2:0] REG_V0_LO = 3'd0;
    localparam logic [2:0] REG_V1_LO = 3'd1;
    localparam logic [2:0] REG_V1_HI = 3'd2;
    localparam logic [2:0] REG_CTRL  = 3'd3;
    localparam logic [2:0] REG_V0_HI = 3'd4;

    // Decoded operations passed from front to back
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic       addr_ok;
        logic [2:0] idx;
        logic [7:0] data;
    } t_op;

    // Result kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    // Tick counts and quotient width
    localparam int DIV_STEPS = 14;
    localparam int QIDX_W    = $clog2(DIV_STEPS);
    localparam int COUNT_W   = 11;

    typedef logic [DIV_STEPS-1:0] t_ticks;
    typedef logic [COUNT_W-1:0]   t_count;

    typedef struct packed {
        logic              busy;
        logic              qbit_valid;
        logic              qbit;
        logic [QIDX_W-1:0] qidx;
    } t_div_status;

    localparam logic [13:0] VOL_MAX = 14'h3fff;

    function automatic logic [13:0] volume_of(input logic [3:0] idx);
        return idx[3] ? VOL_MAX : {idx[2:0], 11'd0};
    endfunction

    // 1023 minus the reload value, with zero standing for 1024
    function automatic t_count period_of(input logic [9:0] reload);
        logic [9:0] p;
        p = 10'd1023 - reload;
        return (p == 10'd0) ? 11'd1024 : {1'b0, p};
    endfunction

    // Noise register as an affine map over GF(2): next = L(n) ^ ofs
    typedef struct packed {
        logic [7:0][7:0] cols;
        logic [7:0]      ofs;
    } t_affine;

    localparam int NOISE_JUMPS = DIV_STEPS;
    typedef t_affine [NOISE_JUMPS-1:0] t_jump_table;

    function automatic logic [7:0] noise_linear(input logic [7:0] n);
        return {n[6:0], n[7] ^ n[5] ^ n[4] ^ n[1]};
    endfunction

    function automatic logic [7:0] lin_apply(input logic [7:0][7:0] cols, input logic [7:0] v);
        logic [7:0] acc;
        acc = 8'd0;
        for (int j = 0; j < 8; j++) begin
            if (v[j]) acc = acc ^ cols[j];
        end
        return acc;
    endfunction

    // Entry 0 is the one-step noise map; each further entry is the previous one applied twice
    function automatic t_jump_table build_jump_table();
        t_jump_table tab;
        t_affine     cur;
        t_affine     nxt;
        for (int j = 0; j < 8; j++) begin
            cur.cols[j] = noise_linear(8'b1 << j);
        end
        cur.ofs = 8'h01;
        for (int k = 0; k < NOISE_JUMPS; k++) begin
            tab[k] = cur;
            for (int j = 0; j < 8; j++) begin
                nxt.cols[j] = lin_apply(cur.cols, cur.cols[j]);
            end
            nxt.ofs = lin_apply(cur.cols, cur.ofs) ^ cur.ofs;
            cur = nxt;
        end
        return tab;
    endfunction

    localparam t_jump_table NOISE_JUMP = build_jump_table();

    function automatic logic [7:0] noise_advance(input t_affine m, input logic [7:0] n);
        return lin_apply(m.cols, n) ^ m.ofs;
    endfunction

endpackage

// ----- rtl/core/tvsn_front.sv -----
// Front end: decodes incoming items into operations for the back end.
// Depends on tvsn_pkg; drops items that have no effect (unused command, write off the map).

module tvsn_front import tvsn_pkg::*; (
    input  logic       i_push,
    input  logic       i_full,
    input  logic [1:0] i_command,
    input  logic [7:0] i_reg_addr,
    input  logic [7:0] i_write_data,
    output logic       o_q_push,
    output t_op        o_q_op
);

    logic       addr_ok;
    logic [7:0] addr_off;
    logic       keep;

    assign addr_ok  = (i_reg_addr >= ADDR_FIRST) && (i_reg_addr <= ADDR_LAST);
    assign addr_off = i_reg_addr - ADDR_FIRST;

    always_comb begin
        o_q_op.addr_ok = addr_ok;
        o_q_op.idx     = addr_off[2:0];
        o_q_op.data    = i_write_data;
        unique case (i_command)
            CMD_SAMPLE: begin
                o_q_op.kind = OP_SAMPLE;
                keep        = 1'b1;
            end
            CMD_WRITE: begin
                o_q_op.kind = OP_WRITE;
                keep        = addr_ok;
            end
            CMD_READ: begin
                o_q_op.kind = OP_READ;
                keep        = 1'b1;
            end
            default: begin
                o_q_op.kind = OP_SAMPLE;
                keep        = 1'b0;
            end
        endcase
    end

    assign o_q_push = i_push && !i_full && keep;

endmodule

// ----- rtl/core/tvsn_queue.sv -----
// Short operation queue between front and back end.
// Depends on tvsn_pkg for the operation type.

module tvsn_queue import tvsn_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    input  logic i_pop,
    output t_op  o_op,
    output logic o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_op              r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_op    = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) n_count = r_count + 1'b1;
        else if (do_pop && !do_push) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_op;
    end

endmodule

// ----- rtl/core/tvsn_div.sv -----
// Restoring divider, one quotient bit per cycle, MSB first.
// Depends on tvsn_pkg; each quotient bit is reported as it is found.

module tvsn_div import tvsn_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_ticks      i_dividend,
    input  t_count      i_divisor,
    output t_div_status o_status,
    output t_ticks      o_quotient,
    output t_count      o_remainder
);

    logic              r_busy, n_busy;
    logic [QIDX_W-1:0] r_idx, n_idx;
    t_ticks            r_dvd, n_dvd;
    t_ticks            r_quo, n_quo;
    t_count            r_rem, n_rem;
    t_count            r_div;
    logic [COUNT_W:0]  trial;
    logic [COUNT_W:0]  diff;
    logic              ge;

    assign trial = {r_rem, r_dvd[DIV_STEPS-1]};
    assign ge    = (trial >= {1'b0, r_div});
    assign diff  = trial - {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        n_dvd  = r_dvd;
        n_quo  = r_quo;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_idx  = QIDX_W'(DIV_STEPS - 1);
            n_dvd  = i_dividend;
            n_quo  = '0;
            n_rem  = '0;
        end else if (r_busy) begin
            n_rem = ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
            n_quo = {r_quo[DIV_STEPS-2:0], ge};
            n_dvd = {r_dvd[DIV_STEPS-2:0], 1'b0};
            n_idx = r_idx - 1'b1;
            if (r_idx == '0) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_dvd <= n_dvd;
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_start) r_div <= i_divisor;
    end

    assign o_status.busy       = r_busy;
    assign o_status.qbit_valid = r_busy;
    assign o_status.qbit       = ge;
    assign o_status.qidx       = r_idx;
    assign o_quotient          = r_quo;
    assign o_remainder         = r_rem;

endmodule

// ----- rtl/core/tvsn_back.sv -----
// Back end: register file, sample position, voice counters, noise register and result register.
// Depends on tvsn_pkg and tvsn_div (two instances, one per voice).

module tvsn_back import tvsn_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_op                   i_q_op,
    input  logic                  i_q_empty,
    output logic                  o_q_pop,
    input  logic                  i_pop,
    output logic                  o_empty,
    output logic                  o_result_kind,
    output logic [14:0]           o_sample_value,
    output logic [7:0]            o_read_data
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_FRAC    = 3'd1;
    localparam logic [2:0] S_WHOLE   = 3'd2;
    localparam logic [2:0] S_START   = 3'd3;
    localparam logic [2:0] S_DIV     = 3'd4;
    localparam logic [2:0] S_FINISH  = 3'd5;
    localparam logic [2:0] S_DELIVER = 3'd6;

    // Configuration
    logic [17:0] r_sample_rate;
    logic [15:0] r_step_whole;
    logic [17:0] r_step_fraction;

    // Register file
    logic [7:0] r_v0_lo, n_v0_lo;
    logic [7:0] r_v1_lo, n_v1_lo;
    logic [1:0] r_v1_hi, n_v1_hi;
    logic [7:0] r_ctl, n_ctl;
    logic [1:0] r_v0_hi, n_v0_hi;

    // Sound state
    logic [2:0]  r_state, n_state;
    t_count      r_count0, n_count0;
    t_count      r_count1, n_count1;
    logic        r_level0, n_level0;
    logic        r_level1, n_level1;
    logic [7:0]  r_noise, n_noise;
    logic [2:0]  r_pos_whole, n_pos_whole;
    logic [17:0] r_pos_frac, n_pos_frac;
    logic        r_carry, n_carry;
    t_ticks      r_ticks, n_ticks;
    logic        r_hit0, n_hit0;
    logic        r_hit1, n_hit1;

    // Result register
    logic        r_out_valid, n_out_valid;
    logic        r_out_kind;
    logic [14:0] r_out_sample;
    logic [7:0]  r_out_data;

    logic        load;
    logic        load_kind;
    logic [14:0] load_sample;
    logic [7:0]  load_data;
    logic        slot_free;
    logic        div_start;

    logic [13:0] vol;
    logic        en0, en1, noise_mode, digital;
    logic [14:0] digital_sum, mix_sum, mix0, mix1;
    logic [18:0] frac_sum, frac_less;
    logic        frac_carry;
    logic [16:0] whole_sum;
    t_count      period0, period1;
    logic        hit0, hit1;
    t_ticks      delay0, delay1;
    logic [7:0]  read_byte;

    t_div_status st0, st1;
    t_ticks      quo0, quo1;
    t_count      rem0, rem1;

    tvsn_div u_div0 (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (delay0),
        .i_divisor   (period0),
        .o_status    (st0),
        .o_quotient  (quo0),
        .o_remainder (rem0)
    );

    tvsn_div u_div1 (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (delay1),
        .i_divisor   (period1),
        .o_status    (st1),
        .o_quotient  (quo1),
        .o_remainder (rem1)
    );

    assign slot_free  = !r_out_valid || i_pop;
    assign vol        = volume_of(r_ctl[3:0]);
    assign en0        = r_ctl[4];
    assign en1        = |r_ctl[6:5];
    assign noise_mode = (r_ctl[6:5] == 2'b10);
    assign digital    = r_ctl[7];

    assign digital_sum = (en0 && en1) ? {vol, 1'b0} : ((en0 || en1) ? {1'b0, vol} : 15'd0);
    assign mix0        = (en0 && r_level0) ? {1'b0, vol} : 15'd0;
    assign mix1        = (en1 && (noise_mode ? !r_noise[0] : r_level1)) ? {1'b0, vol} : 15'd0;
    assign mix_sum     = mix0 + mix1;

    assign frac_sum   = {1'b0, r_pos_frac} + {1'b0, r_step_fraction};
    assign frac_carry = (frac_sum >= {1'b0, r_sample_rate});
    assign frac_less  = frac_sum - {1'b0, r_sample_rate};
    assign whole_sum  = 17'(r_pos_whole) + 17'(r_carry) + {1'b0, r_step_whole};

    assign period0 = period_of({r_v0_hi, r_v0_lo});
    assign period1 = period_of({r_v1_hi, r_v1_lo});
    assign hit0    = ({3'd0, r_count0} <= r_ticks);
    assign hit1    = ({3'd0, r_count1} <= r_ticks);
    assign delay0  = r_ticks - {3'd0, r_count0};
    assign delay1  = r_ticks - {3'd0, r_count1};

    always_comb begin
        read_byte = 8'd0;
        if (i_q_op.addr_ok) begin
            case (i_q_op.idx)
                REG_V0_LO: read_byte = r_v0_lo;
                REG_V1_LO: read_byte = r_v1_lo;
                REG_V1_HI: read_byte = {6'd0, r_v1_hi} | READ_HI_MASK;
                REG_CTRL:  read_byte = r_ctl;
                REG_V0_HI: read_byte = {6'd0, r_v0_hi};
                default:   read_byte = 8'd0;
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_v0_lo     = r_v0_lo;
        n_v1_lo     = r_v1_lo;
        n_v1_hi     = r_v1_hi;
        n_ctl       = r_ctl;
        n_v0_hi     = r_v0_hi;
        n_count0    = r_count0;
        n_count1    = r_count1;
        n_level0    = r_level0;
        n_level1    = r_level1;
        n_noise     = r_noise;
        n_pos_whole = r_pos_whole;
        n_pos_frac  = r_pos_frac;
        n_carry     = r_carry;
        n_ticks     = r_ticks;
        n_hit0      = r_hit0;
        n_hit1      = r_hit1;
        o_q_pop     = 1'b0;
        div_start   = 1'b0;
        load        = 1'b0;
        load_kind   = KIND_SAMPLE;
        load_sample = 15'd0;
        load_data   = 8'd0;

        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    unique case (i_q_op.kind)
                        OP_WRITE: begin
                            o_q_pop = 1'b1;
                            case (i_q_op.idx)
                                REG_V0_LO: n_v0_lo = i_q_op.data;
                                REG_V1_LO: n_v1_lo = i_q_op.data;
                                REG_V1_HI: n_v1_hi = i_q_op.data[1:0];
                                REG_CTRL: begin
                                    n_ctl = i_q_op.data;
                                    // entering digital mode parks both voices high
                                    if (i_q_op.data[7]) begin
                                        n_level0 = 1'b1;
                                        n_level1 = 1'b1;
                                        n_count0 = '0;
                                        n_count1 = '0;
                                        n_noise  = 8'd0;
                                    end
                                end
                                REG_V0_HI: n_v0_hi = i_q_op.data[1:0];
                                default: ;
                            endcase
                        end
                        OP_READ: begin
                            if (slot_free) begin
                                o_q_pop   = 1'b1;
                                load      = 1'b1;
                                load_kind = KIND_READ;
                                load_data = read_byte;
                            end
                        end
                        OP_SAMPLE: begin
                            if (digital) begin
                                if (slot_free) begin
                                    o_q_pop     = 1'b1;
                                    load        = 1'b1;
                                    load_sample = digital_sum;
                                end
                            end else begin
                                o_q_pop = 1'b1;
                                n_state = S_FRAC;
                            end
                        end
                        default: o_q_pop = 1'b1;
                    endcase
                end
            end
            S_FRAC: begin
                n_pos_frac = frac_carry ? frac_less[17:0] : frac_sum[17:0];
                n_carry    = frac_carry;
                n_state    = S_WHOLE;
            end
            S_WHOLE: begin
                n_pos_whole = whole_sum[2:0];
                n_ticks     = whole_sum[16:3];
                n_state     = (whole_sum[16:3] != '0) ? S_START : S_DELIVER;
            end
            S_START: begin
                n_hit0    = hit0;
                n_hit1    = hit1;
                div_start = 1'b1;
                if (!hit0) n_count0 = r_count0 - r_ticks[COUNT_W-1:0];
                if (!hit1) n_count1 = r_count1 - r_ticks[COUNT_W-1:0];
                // the first toggle clocks the noise register once
                if (hit1) n_noise = noise_advance(NOISE_JUMP[0], r_noise);
                n_state = S_DIV;
            end
            S_DIV: begin
                // each quotient bit k set adds 2**k more noise clocks
                if (r_hit1 && st1.qbit_valid && st1.qbit) begin
                    n_noise = noise_advance(NOISE_JUMP[st1.qidx], r_noise);
                end
                if (!st0.busy) n_state = S_FINISH;
            end
            S_FINISH: begin
                if (r_hit0) begin
                    n_count0 = period0 - rem0;
                    n_level0 = r_level0 ^ ~quo0[0];
                end
                if (r_hit1) begin
                    n_count1 = period1 - rem1;
                    n_level1 = r_level1 ^ ~quo1[0];
                end
                n_state = S_DELIVER;
            end
            S_DELIVER: begin
                if (slot_free) begin
                    load        = 1'b1;
                    load_sample = mix_sum;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (load) n_out_valid = 1'b1;
        else if (i_pop) n_out_valid = 1'b0;
        else n_out_valid = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_v0_lo     <= 8'd0;
            r_v1_lo     <= 8'd0;
            r_v1_hi     <= 2'd0;
            r_ctl       <= 8'd0;
            r_v0_hi     <= 2'd0;
            r_count0    <= '0;
            r_count1    <= '0;
            r_level0    <= 1'b0;
            r_level1    <= 1'b0;
            r_noise     <= 8'd0;
            r_pos_whole <= 3'd0;
            r_pos_frac  <= 18'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_v0_lo     <= n_v0_lo;
            r_v1_lo     <= n_v1_lo;
            r_v1_hi     <= n_v1_hi;
            r_ctl       <= n_ctl;
            r_v0_hi     <= n_v0_hi;
            r_count0    <= n_count0;
            r_count1    <= n_count1;
            r_level0    <= n_level0;
            r_level1    <= n_level1;
            r_noise     <= n_noise;
            r_pos_whole <= n_pos_whole;
            r_pos_frac  <= n_pos_frac;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_carry <= n_carry;
        r_ticks <= n_ticks;
        r_hit0  <= n_hit0;
        r_hit1  <= n_hit1;
        if (load) begin
            r_out_kind   <= load_kind;
            r_out_sample <= load_sample;
            r_out_data   <= load_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_rate   <= SAMPLE_RATE_RESET;
            r_step_whole    <= STEP_WHOLE_RESET;
            r_step_fraction <= STEP_FRACTION_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SAMPLE_RATE:   r_sample_rate   <= i_cfg_data;
                CFG_STEP_WHOLE:    r_step_whole    <= i_cfg_data[15:0];
                CFG_STEP_FRACTION: r_step_fraction <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_result_kind  = r_out_kind;
    assign o_sample_value = r_out_sample;
    assign o_read_data    = r_out_data;

endmodule

// ----- rtl/core/two_voice_square_noise_sound_gen.sv -----
// Top level of the two-voice square/noise sound generator.
// Depends on tvsn_pkg, tvsn_front, tvsn_queue and tvsn_back.
//
// channel   | handshake                  | payload
// ----------+----------------------------+--------------------------------------------
// input     | push / full                | i_command, i_reg_addr, i_write_data
// result    | empty / pop                | o_result_kind, o_sample_value, o_read_data
// config    | i_cfg_we (no wait)         | i_cfg_index, i_cfg_data
//
// Writes and reads are handled in the idle state; a sample that lets at least one tick elapse
// passes through pop, fraction, whole, divider start, the divider run, finish and load; one with
// no tick goes from whole straight to load, and in digital mode a sample is loaded at pop.
// Reset is synchronous and active low; it restores the config defaults and clears the register file,
// the voice, noise and position state, the queue and the result valid flag. A waiting result stalls the
// back end at the next item that produces one; the operation queue then fills and raises full.

module two_voice_square_noise_sound_gen import tvsn_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic [1:0]            i_command,
    input  logic [7:0]            i_reg_addr,
    input  logic [7:0]            i_write_data,
    output logic                  empty,
    input  logic                  pop,
    output logic                  o_result_kind,
    output logic [14:0]           o_sample_value,
    output logic [7:0]            o_read_data
);

    logic q_push, q_pop, q_empty;
    t_op  q_in_op, q_out_op;

    tvsn_front u_front (
        .i_push       (push),
        .i_full       (full),
        .i_command    (i_command),
        .i_reg_addr   (i_reg_addr),
        .i_write_data (i_write_data),
        .o_q_push     (q_push),
        .o_q_op       (q_in_op)
    );

    tvsn_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (q_in_op),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_op    (q_out_op),
        .o_empty (q_empty)
    );

    tvsn_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_q_op         (q_out_op),
        .i_q_empty      (q_empty),
        .o_q_pop        (q_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_result_kind  (o_result_kind),
        .o_sample_value (o_sample_value),
        .o_read_data    (o_read_data)
    );

endmodule

// ----- rtl/core/tvsn_checker.sv -----
// Port-level checks for the sound generator, attached by bind.
// Depends only on the top level's ports.

module tvsn_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic        o_result_kind,
    input logic [14:0] o_sample_value,
    input logic [7:0]  o_read_data
);

    // reset leaves no result pending and room for input
    a_reset_clear: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("results pending or queue full after reset");

    // hold a waiting result until it is taken
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_result_kind) && $stable(o_sample_value)
            && $stable(o_read_data))
        else $error("waiting result changed or vanished");

    // the field of the other kind stays zero
    a_kind_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result_kind ? (o_sample_value == 15'd0) : (o_read_data == 8'd0)))
        else $error("result carries data of the other kind");

    // two voices at full volume is the largest sample
    a_sample_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_result_kind |-> o_sample_value <= 15'h7ffe)
        else $error("sample above two full voices");

endmodule

bind two_voice_square_noise_sound_gen tvsn_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .full           (full),
    .empty          (empty),
    .pop            (pop),
    .o_result_kind  (o_result_kind),
    .o_sample_value (o_sample_value),
    .o_read_data    (o_read_data)
);
